FILE: sv/hamming_sec_decoder_macros.svh
// Assertion macros for the checker file of the SEC decoder.
// Depends on a clk and an active-low arst_n in the scope of use.
`ifndef HAMMING_SEC_DECODER_MACROS_SVH
`define HAMMING_SEC_DECODER_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define HSD_ASSERT_NOW(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// Next-cycle implication, disabled while in reset
`define HSD_ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

FILE: sv/hsd_pkg.sv
// Shared widths, reset value and code geometry for the SEC decoder.
// No dependencies; imported by every decoder module.
package hsd_pkg;

	localparam int CW_W   = 62;
	localparam int DATA_W = 56;
	localparam int SYN_W  = 6;
	localparam int DB_W   = 3;
	localparam int R_W    = 3;

	localparam logic [DB_W-1:0] DB_RESET = 3'd4;

	// Syndrome and correction flag handed from the syndrome stage
	typedef struct packed {
		logic [SYN_W-1:0] syndrome;
		logic             corrected;
	} dec_t;

	// Codeword length n for a given data byte count
	function automatic logic [SYN_W-1:0] code_len(input logic [DB_W-1:0] db);
		logic [SYN_W-1:0] n;
		case (db)
			3'd0:    n = 6'd0;
			3'd1:    n = 6'd12;
			3'd2:    n = 6'd21;
			3'd3:    n = 6'd29;
			3'd4:    n = 6'd38;
			3'd5:    n = 6'd46;
			3'd6:    n = 6'd54;
			3'd7:    n = 6'd62;
			default: n = 6'd0;
		endcase
		return n;
	endfunction

	// Number of check bits r for a given data byte count
	function automatic logic [R_W-1:0] chk_bits(input logic [DB_W-1:0] db);
		logic [R_W-1:0] r;
		case (db)
			3'd0:    r = 3'd0;
			3'd1:    r = 3'd4;
			3'd2:    r = 3'd5;
			3'd3:    r = 3'd5;
			default: r = 3'd6;
		endcase
		return r;
	endfunction

	// One-based codeword position of data bit k (k-th non power of two)
	function automatic int data_pos(input int k);
		int cnt;
		int pos;
		cnt = 0;
		pos = 0;
		for (int p = 1; p <= CW_W; p++) begin
			if ((p & (p - 1)) != 0) begin
				if (cnt == k && pos == 0) begin
					pos = p;
				end
				cnt++;
			end
		end
		return pos;
	endfunction

endpackage

FILE: sv/hsd_syndrome.sv
// Syndrome tree and single-bit correction for the SEC decoder.
// Depends on hsd_pkg.
module hsd_syndrome
	import hsd_pkg::*;
(
	input  logic [CW_W-1:0]  word,
	input  logic [SYN_W-1:0] n,
	input  logic [R_W-1:0]   r,
	output logic [CW_W-1:0]  fixed,
	output dec_t             dec
);

	logic [CW_W-1:0]  word_m;
	logic [SYN_W-1:0] syn_full;
	logic [SYN_W-1:0] syn_mask;
	logic [SYN_W-1:0] syn;
	logic             hit;
	logic [CW_W-1:0]  flip;

	// Drop bits beyond the codeword length
	always_comb begin
		for (int p = 1; p <= CW_W; p++) begin
			word_m[p-1] = word[p-1] & (SYN_W'(p) <= n);
		end
	end

	// XOR every bit into the syndrome bits its position selects
	always_comb begin
		for (int j = 0; j < SYN_W; j++) begin
			syn_full[j] = 1'b0;
			for (int p = 1; p <= CW_W; p++) begin
				if (((p >> j) & 1) == 1) begin
					syn_full[j] = syn_full[j] ^ word_m[p-1];
				end
			end
			syn_mask[j] = (R_W'(j) < r);
		end
	end

	assign syn = syn_full & syn_mask;
	assign hit = (syn != '0) && (syn <= n);

	// Flip the named bit when it lies inside the codeword
	always_comb begin
		for (int p = 1; p <= CW_W; p++) begin
			flip[p-1] = hit && (syn == SYN_W'(p));
		end
	end

	assign fixed        = word ^ flip;
	assign dec.syndrome = syn;
	assign dec.corrected = hit;

endmodule

FILE: sv/hsd_extract.sv
// Data bit extraction: drop check positions, first data bit on top.
// Depends on hsd_pkg.
module hsd_extract
	import hsd_pkg::*;
(
	input  logic [CW_W-1:0]   word,
	input  logic [DB_W-1:0]   db,
	output logic [DATA_W-1:0] data
);

	logic [DATA_W-1:0] rev;
	logic [SYN_W-1:0]  shamt;

	// Wire data positions in reverse order, first data bit at the top
	for (genvar k = 0; k < DATA_W; k++) begin : g_pick
		localparam int Pos = data_pos(k);
		assign rev[DATA_W-1-k] = word[Pos-1];
	end

	// Align the m data bits to the bottom: shift by 8 * (7 - db)
	assign shamt = {3'd7 - db, 3'b000};
	assign data  = rev >> shamt;

endmodule

FILE: sv/hamming_sec_decoder.sv
// Shortened Hamming single-error-correcting decoder; depends on hsd_pkg, hsd_syndrome, hsd_extract.
// An accepted beat passes through the input register and then the result register,
// where it waits on the output while out_ready is low.
// Throughput: one beat per cycle while out_ready is high, set by the single
// syndrome/correct/extract pass between the input register and the result register.
// Reset clears both valid flags and loads data_bytes with 4.
module hamming_sec_decoder
	import hsd_pkg::*;
#(
	parameter int MAX_DATA_BYTES = 7
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [DB_W-1:0]   cfg_wdata,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [CW_W-1:0]   codeword,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [DATA_W-1:0] data,
	output logic [SYN_W-1:0]  syndrome,
	output logic              corrected
);

	logic [DB_W-1:0]   data_bytes_q;
	logic [DB_W-1:0]   eff_db;
	logic              valid_s1;
	logic              valid_s2;
	logic              adv_s1;
	logic              adv_s2;
	logic [CW_W-1:0]   word_s1;
	logic [CW_W-1:0]   fixed;
	dec_t              dec;
	logic [DATA_W-1:0] data_c;
	logic [DATA_W-1:0] data_s2;
	logic [SYN_W-1:0]  syndrome_s2;
	logic              corrected_s2;

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_bytes_q <= DB_RESET;
		end else if (cfg_we) begin
			data_bytes_q <= cfg_wdata;
		end
	end

	// Saturate the byte count
	assign eff_db = (data_bytes_q > DB_W'(MAX_DATA_BYTES)) ? DB_W'(MAX_DATA_BYTES)
		: data_bytes_q;

	// Pipeline advance: a stage loads when empty or when its beat moves on
	assign adv_s2   = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || adv_s2;
	assign adv_s1   = in_valid && in_ready;

	// Hold valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (!valid_s2 || out_ready) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// Input register
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			word_s1 <= codeword;
		end
	end

	hsd_syndrome u_syndrome (
		.word  (word_s1),
		.n     (code_len(eff_db)),
		.r     (chk_bits(eff_db)),
		.fixed (fixed),
		.dec   (dec)
	);

	hsd_extract u_extract (
		.word (fixed),
		.db   (eff_db),
		.data (data_c)
	);

	// Result register
	always_ff @(posedge clk) begin
		if (adv_s2) begin
			data_s2      <= data_c;
			syndrome_s2  <= dec.syndrome;
			corrected_s2 <= dec.corrected;
		end
	end

	assign out_valid = valid_s2;
	assign data      = data_s2;
	assign syndrome  = syndrome_s2;
	assign corrected = corrected_s2;

endmodule

FILE: sv/hsd_checker.sv
// Port-level checker for the SEC decoder, bound to the top level.
// Depends on hsd_pkg and hamming_sec_decoder_macros.svh.
`include "hamming_sec_decoder_macros.svh"

module hsd_checker
	import hsd_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input logic [DATA_W-1:0] data,
	input logic [SYN_W-1:0]  syndrome,
	input logic              corrected
);

	// A stalled result beat stays and holds its payload
	`HSD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result beat dropped")
	`HSD_ASSERT_NEXT(a_out_stable, out_valid && !out_ready,
		$stable(data) && $stable(syndrome) && $stable(corrected), "stalled result changed")

	// Input backs up only when both stages are full and the output stalls
	`HSD_ASSERT_NOW(a_ready, !in_ready, out_valid && !out_ready, "input stalled without cause")

	// A correction always comes with a non-zero syndrome
	`HSD_ASSERT_NOW(a_corr, out_valid && corrected, syndrome != '0, "correction without syndrome")

endmodule

bind hamming_sec_decoder hsd_checker u_hsd_checker (.*);
